// ===== hw/rtl/art_pkg.sv =====
// art_pkg: shared constants, codes and types for the ack retransmit table
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package art_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // results one tick may report
    localparam int RESULT_CAP = 16;
    localparam int RCNT_W     = $clog2(RESULT_CAP + 1);

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int QPTR_W     = $clog2(CMDQ_DEPTH);
    localparam int QCNT_W     = $clog2(CMDQ_DEPTH + 1);

    // field widths
    localparam int MODE_W    = 2;
    localparam int ID_W      = 32;
    localparam int TYPE_W    = 4;
    localparam int STAMP_W   = 32;
    localparam int EV_W      = 2;
    localparam int RETRY_W   = 4;
    localparam int TIMEOUT_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    // result event codes
    localparam logic [EV_W-1:0] EV_RESEND  = 2'd0;
    localparam logic [EV_W-1:0] EV_GIVEUP  = 2'd1;
    localparam logic [EV_W-1:0] EV_DROPPED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_SECS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_MAX = 1'd1;

    // reset values of the configuration registers
    localparam logic [TIMEOUT_W-1:0] WAIT_SECS_RST = 8'd3;
    localparam logic [RETRY_W-1:0]   RETRY_MAX_RST = 4'd3;

    // classified operations
    typedef enum logic [1:0] {
        OP_ADD,
        OP_ACK,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [ID_W-1:0]    id;
        logic [TYPE_W-1:0]  typ;
        logic [STAMP_W-1:0] stamp;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TYPE_W-1:0]  typ;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] sent;
        logic [RETRY_W-1:0] retries;
    } entry_t;

    typedef struct packed {
        logic [EV_W-1:0]    ev;
        logic [ID_W-1:0]    id;
        logic [TYPE_W-1:0]  typ;
        logic [STAMP_W-1:0] stamp;
        logic [RETRY_W-1:0] retries;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] wait_secs;
        logic [RETRY_W-1:0]   retry_max;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/art_in_if.sv =====
// art_in_if: input request channel of the ack retransmit table
// depends on art_pkg for field widths
`default_nettype none

interface art_in_if;
    logic                        valid;
    logic                        ready;
    logic [art_pkg::MODE_W-1:0]  mode;
    logic [art_pkg::ID_W-1:0]    msg_id;
    logic [art_pkg::TYPE_W-1:0]  msg_type;
    logic [art_pkg::STAMP_W-1:0] orig_stamp;

    modport source (output valid, output mode, output msg_id, output msg_type,
                    output orig_stamp, input ready);
    modport sink   (input valid, input mode, input msg_id, input msg_type,
                    input orig_stamp, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/art_out_if.sv =====
// art_out_if: result channel of the ack retransmit table
// depends on art_pkg for field widths
`default_nettype none

interface art_out_if;
    logic                        valid;
    logic                        ready;
    logic [art_pkg::EV_W-1:0]    event_res;
    logic [art_pkg::ID_W-1:0]    out_id;
    logic [art_pkg::TYPE_W-1:0]  out_type;
    logic [art_pkg::STAMP_W-1:0] out_stamp;
    logic [art_pkg::RETRY_W-1:0] retry_count;
    logic                        last;

    modport source (output valid, output event_res, output out_id, output out_type,
                    output out_stamp, output retry_count, output last, input ready);
    modport sink   (input valid, input event_res, input out_id, input out_type,
                    input out_stamp, input retry_count, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/art_cfg_if.sv =====
// art_cfg_if: configuration write channel of the ack retransmit table
// depends on art_pkg for index and data widths
`default_nettype none

interface art_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [art_pkg::CFG_IDX_W-1:0] index;
    logic [art_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ack_retransmit_table.sv =====
// ack_retransmit_table: top level; configuration registers, front, queue, back
// depends on art_pkg, art_in_if, art_out_if, art_cfg_if and all art_ modules
//
// channel  dir  request contents
// item     in   mode, msg_id, msg_type, orig_stamp
// result   out  event_res, out_id, out_type, out_stamp, retry_count, last
// cfg      in   index (0 resend timeout, 1 retry limit), data
//
// an add is handled in the idle state of the table engine and goes through
// the flush state when the table is full and the drop is reported; an ack or
// a tick starts in idle, then the scan state walks the stored entries (up to
// 16) with the single table read port, and flush sends the last report if any.
// a two-deep command queue lets requests arrive while a scan runs.
// the scan holds when a report is ready and the output register is full.
// reset clears counts, time, state and config; the table needs no clearing pass.
`default_nettype none

module ack_retransmit_table (
    input  logic     clk,
    input  logic     rst_n,
    art_in_if.sink   item,
    art_cfg_if.sink  cfg,
    art_out_if.source result
);
    import art_pkg::*;

    cfg_t cfg_reg;
    logic q_push_valid;
    logic q_push_ready;
    cmd_t q_push_cmd;
    logic q_pop_valid;
    logic q_pop_ready;
    cmd_t q_pop_cmd;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_secs <= WAIT_SECS_RST;
            cfg_reg.retry_max <= RETRY_MAX_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_WAIT_SECS:
                begin
                    cfg_reg.wait_secs <= cfg.data[TIMEOUT_W-1:0];
                end
                CFG_RETRY_MAX:
                begin
                    cfg_reg.retry_max <= cfg.data[RETRY_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // request classification
    art_front u_front (
        .item       (item),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_cmd   (q_push_cmd)
    );

    // command queue
    art_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_cmd   (q_push_cmd),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_cmd    (q_pop_cmd)
    );

    // table engine
    art_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (q_pop_valid),
        .cmd_ready (q_pop_ready),
        .cmd       (q_pop_cmd),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/art_front.sv =====
// art_front: accepts input requests and classifies them into table commands
// depends on art_pkg and art_in_if; feeds art_cmd_fifo
`default_nettype none

module art_front (
    art_in_if.sink        item,
    output logic          push_valid,
    input  logic          push_ready,
    output art_pkg::cmd_t push_cmd
);
    import art_pkg::*;

    // an unused mode is taken and dropped here, never queued
    assign item.ready = push_ready;

    // decode the mode into an operation
    always_comb
    begin
        push_valid     = 1'b0;
        push_cmd.op    = OP_ADD;
        push_cmd.id    = item.msg_id;
        push_cmd.typ   = item.msg_type;
        push_cmd.stamp = item.orig_stamp;
        unique case (item.mode)
            MODE_ADD:
            begin
                push_valid  = item.valid;
                push_cmd.op = OP_ADD;
            end
            MODE_ACK:
            begin
                push_valid  = item.valid;
                push_cmd.op = OP_ACK;
            end
            MODE_TICK:
            begin
                push_valid  = item.valid;
                push_cmd.op = OP_TICK;
            end
            MODE_NONE:
            begin
                push_valid = 1'b0;
            end
            default:
            begin
                push_valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/art_cmd_fifo.sv =====
// art_cmd_fifo: short command queue between the front and the back
// depends on art_pkg for the command type and queue depth
`default_nettype none

module art_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  art_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output art_pkg::cmd_t pop_cmd
);
    import art_pkg::*;

    cmd_t              fifo_mem [CMDQ_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != QCNT_W'(CMDQ_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = fifo_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        priority if (do_push && !do_pop)
        begin
            fill_next = QCNT_W'(fill_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = QCNT_W'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/art_back.sv =====
// art_back: table engine; adds entries, compacts on ack and timeout scans
// depends on art_pkg and art_out_if; takes commands from art_cmd_fifo
`default_nettype none

module art_back (
    input  logic          clk,
    input  logic          rst_n,
    input  art_pkg::cfg_t cfg,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  art_pkg::cmd_t cmd,
    art_out_if.source     result
);
    import art_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    // table storage, packed oldest first
    entry_t tbl_mem [TABLE_DEPTH];

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [STAMP_W-1:0] now_reg;
    logic [STAMP_W-1:0] now_next;
    logic [CNT_W-1:0]   rd_reg;
    logic [CNT_W-1:0]   rd_next;
    logic [CNT_W-1:0]   wr_reg;
    logic [CNT_W-1:0]   wr_next;
    logic [RCNT_W-1:0]  nres_reg;
    logic [RCNT_W-1:0]  nres_next;
    op_t                op_reg;
    op_t                op_next;
    logic [ID_W-1:0]    key_reg;
    logic [ID_W-1:0]    key_next;
    logic               found_reg;
    logic               found_next;
    logic               held_valid_reg;
    logic               held_valid_next;
    result_t            held_reg;
    result_t            held_next;
    logic               out_valid_reg;
    result_t            out_reg;
    entry_t             rd_entry_reg;

    logic               out_free;
    logic               out_load;
    result_t            out_data;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
    logic [STAMP_W-1:0] age;
    logic               due;
    logic               give_up;
    logic               drop_hit;
    logic               keep;
    logic               stall;
    logic               last_entry;
    logic [CNT_W-1:0]   wr_step;
    logic [RETRY_W-1:0] bumped;

    assign out_free = !out_valid_reg || result.ready;

    // examine the entry under the read pointer
    assign age        = now_reg - rd_entry_reg.sent;
    assign bumped     = RETRY_W'(rd_entry_reg.retries + 1'b1);
    assign due        = (op_reg == OP_TICK) && (nres_reg < RCNT_W'(RESULT_CAP))
                        && (age >= STAMP_W'(cfg.wait_secs));
    assign give_up    = (rd_entry_reg.retries >= cfg.retry_max);
    assign drop_hit   = (op_reg == OP_ACK) && !found_reg && (rd_entry_reg.id == key_reg);
    assign keep       = !(drop_hit || (due && give_up));
    assign stall      = due && held_valid_reg && !out_free;
    assign last_entry = (CNT_W'(rd_reg + 1'b1) == count_reg);
    assign wr_step    = keep ? CNT_W'(wr_reg + 1'b1) : wr_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        now_next        = now_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        nres_next       = nres_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        found_next      = found_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        cmd_ready       = 1'b0;
        out_load        = 1'b0;
        out_data        = held_reg;
        we              = 1'b0;
        waddr           = wr_reg[IDX_W-1:0];
        wdata           = rd_entry_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                rd_next   = '0;
                wr_next   = '0;
                if (cmd_valid)
                begin
                    op_next = cmd.op;
                    unique case (cmd.op)
                        OP_ADD:
                        begin
                            if (count_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                we            = 1'b1;
                                waddr         = count_reg[IDX_W-1:0];
                                wdata.id      = cmd.id;
                                wdata.typ     = cmd.typ;
                                wdata.stamp   = cmd.stamp;
                                wdata.sent    = now_reg;
                                wdata.retries = '0;
                                count_next    = CNT_W'(count_reg + 1'b1);
                            end
                            else
                            begin
                                held_next.ev      = EV_DROPPED;
                                held_next.id      = cmd.id;
                                held_next.typ     = cmd.typ;
                                held_next.stamp   = cmd.stamp;
                                held_next.retries = '0;
                                held_next.last    = 1'b0;
                                held_valid_next   = 1'b1;
                                state_next        = S_FLUSH;
                            end
                        end
                        OP_ACK:
                        begin
                            key_next   = cmd.id;
                            found_next = 1'b0;
                            if (count_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_TICK:
                        begin
                            now_next  = STAMP_W'(now_reg + 1'b1);
                            nres_next = '0;
                            if (count_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!stall)
                begin
                    // copy survivors down, updating resent ones
                    we = keep;
                    if (due && !give_up)
                    begin
                        wdata.retries = bumped;
                        wdata.sent    = now_reg;
                    end
                    wr_next = wr_step;
                    rd_next = CNT_W'(rd_reg + 1'b1);
                    if (drop_hit)
                    begin
                        found_next = 1'b1;
                    end
                    // report; the previous report moves to the output stage
                    if (due)
                    begin
                        out_load          = held_valid_reg;
                        held_next.ev      = give_up ? EV_GIVEUP : EV_RESEND;
                        held_next.id      = rd_entry_reg.id;
                        held_next.typ     = rd_entry_reg.typ;
                        held_next.stamp   = rd_entry_reg.stamp;
                        held_next.retries = give_up ? rd_entry_reg.retries : bumped;
                        held_next.last    = 1'b0;
                        held_valid_next   = 1'b1;
                        nres_next         = RCNT_W'(nres_reg + 1'b1);
                    end
                    if (last_entry)
                    begin
                        count_next = wr_step;
                        state_next = (held_valid_reg || due) ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_FLUSH:
            begin
                // final report of this request carries last
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_data.last   = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            now_reg        <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            nres_reg       <= '0;
            op_reg         <= OP_ADD;
            found_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            now_reg        <= now_next;
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            nres_reg       <= nres_next;
            op_reg         <= op_next;
            found_reg      <= found_next;
            held_valid_reg <= held_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, table writes and the registered table read
    // the read address runs ahead of every compaction write, so no bypass is needed
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        held_reg     <= held_next;
        rd_entry_reg <= tbl_mem[rd_next[IDX_W-1:0]];
        if (out_load)
        begin
            out_reg <= out_data;
        end
        if (we)
        begin
            tbl_mem[waddr] <= wdata;
        end
    end

    // output stage
    assign result.valid       = out_valid_reg;
    assign result.event_res   = out_reg.ev;
    assign result.out_id      = out_reg.id;
    assign result.out_type    = out_reg.typ;
    assign result.out_stamp   = out_reg.stamp;
    assign result.retry_count = out_reg.retries;
    assign result.last        = out_reg.last;

`ifndef SYNTHESIS
    // table never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // compaction writes never pass the read pointer
    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> (wr_reg <= rd_reg && rd_reg < count_reg))
        else $error("scan pointers out of order");

    // no report is left pending between requests
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !held_valid_reg)
        else $error("pending report while idle");

    // flush always has a report to send
    a_flush_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLUSH |-> held_valid_reg)
        else $error("flush without pending report");

    // the clock only moves on a tick taken from the queue
    a_now_step: assert property (@(posedge clk) disable iff (!rst_n)
        now_reg != $past(now_reg) |-> $past(cmd_valid && cmd_ready && cmd.op == OP_TICK))
        else $error("time advanced without a tick");
`endif

endmodule

`default_nettype wire

// ===== sim/ack_retransmit_table_test.sv =====
// ack_retransmit_table_test: self-checking testbench for the ack retransmit table
// uses art_pkg, art_in_if, art_out_if, art_cfg_if and the ack_retransmit_table rtl
// a table of directed requests, then random phases under several register settings
`default_nettype none

module ack_retransmit_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import art_pkg::*;

    // what a directed row expects: from the table mirror, nothing, or a dropped add
    typedef enum int {
        PREDICTED,
        SILENT,
        DROPPED
    } outcome_t;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [ID_W-1:0]    id;
        logic [TYPE_W-1:0]  typ;
        logic [STAMP_W-1:0] stamp;
        outcome_t           outcome;
    } plan_row_t;

    localparam int PLAN_ROWS      = 25;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 58;
    localparam int HOLD_PHASE     = 3;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 80;
    localparam int MAX_GAP        = 17;

    logic clk = 1'b0;
    logic rst_n;

    art_in_if  item_bus();
    art_out_if report_bus();
    art_cfg_if cfg_bus();

    ack_retransmit_table u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .cfg    (cfg_bus),
        .result (report_bus)
    );

    // mirror of the pending table, oldest first, and the reports it owes
    entry_t               pending[$];
    result_t              awaited[$];
    logic [STAMP_W-1:0]   now_secs;
    logic [TIMEOUT_W-1:0] timeout_secs;
    logic [RETRY_W-1:0]   retry_limit;

    int miss_count   = 0;
    bit hold_go      = 1'b0;
    bit eager_sink   = 1'b0;
    bit eager_source = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic note_mismatch(input string what);
        miss_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // idle cycles before a request or between reports
    function automatic int draw_wait();
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic void push_report(input logic [EV_W-1:0] ev, input entry_t e,
                                        input logic [RETRY_W-1:0] retries);
        result_t rec;
        rec.ev      = ev;
        rec.id      = e.id;
        rec.typ     = e.typ;
        rec.stamp   = e.stamp;
        rec.retries = retries;
        rec.last    = 1'b0;
        awaited.insert(awaited.size(), rec);
    endfunction

    // update the table mirror for one accepted request and queue its reports
    function automatic void apply_item(input logic [MODE_W-1:0] mode,
                                       input logic [ID_W-1:0] id,
                                       input logic [TYPE_W-1:0] typ,
                                       input logic [STAMP_W-1:0] stamp);
        entry_t             fresh;
        logic [STAMP_W-1:0] age;
        int                 i;
        int                 n;
        n = 0;
        case (mode)
            MODE_ADD:
            begin
                fresh.id      = id;
                fresh.typ     = typ;
                fresh.stamp   = stamp;
                fresh.sent    = now_secs;
                fresh.retries = '0;
                if (pending.size() < TABLE_DEPTH)
                    pending.insert(pending.size(), fresh);
                else
                begin
                    push_report(EV_DROPPED, fresh, '0);
                    n = 1;
                end
            end
            MODE_ACK:
            begin
                // only the oldest match goes
                for (i = 0; i < pending.size(); i++)
                begin
                    if (pending[i].id == id)
                    begin
                        pending.delete(i);
                        break;
                    end
                end
            end
            MODE_TICK:
            begin
                now_secs = now_secs + 1'b1;
                i = 0;
                while (i < pending.size() && n < RESULT_CAP)
                begin
                    age = now_secs - pending[i].sent;
                    if (age < timeout_secs)
                        i++;
                    else if (pending[i].retries >= retry_limit)
                    begin
                        push_report(EV_GIVEUP, pending[i], pending[i].retries);
                        pending.delete(i);
                        n++;
                    end
                    else
                    begin
                        pending[i].retries = pending[i].retries + 1'b1;
                        pending[i].sent    = now_secs;
                        push_report(EV_RESEND, pending[i], pending[i].retries);
                        n++;
                        i++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (n > 0)
            awaited[awaited.size() - 1].last = 1'b1;
    endfunction

    function automatic plan_row_t plan_row(input logic [MODE_W-1:0] mode,
                                           input logic [ID_W-1:0] id,
                                           input logic [TYPE_W-1:0] typ,
                                           input logic [STAMP_W-1:0] stamp,
                                           input outcome_t outcome);
        plan_row_t row;
        row.mode    = mode;
        row.id      = id;
        row.typ     = typ;
        row.stamp   = stamp;
        row.outcome = outcome;
        return row;
    endfunction

    // present one request and hold it until the block takes it
    task automatic offer_item(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                              input logic [TYPE_W-1:0] typ, input logic [STAMP_W-1:0] stamp);
        int gap;
        gap = eager_source ? 0 : draw_wait();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.mode       <= mode;
        item_bus.msg_id     <= id;
        item_bus.msg_type   <= typ;
        item_bus.orig_stamp <= stamp;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
    endtask

    // mostly adds, acks of live ids and ticks; a few unused modes and stray acks
    task automatic offer_random_item();
        logic [MODE_W-1:0]  mode;
        logic [ID_W-1:0]    id;
        logic [TYPE_W-1:0]  typ;
        logic [STAMP_W-1:0] stamp;
        int                 pick;
        pick  = $urandom_range(0, 99);
        id    = $urandom();
        typ   = TYPE_W'($urandom_range(0, 15));
        stamp = $urandom();
        if (pick < 40)
        begin
            mode = MODE_ADD;
            // small ids give duplicates
            if ($urandom_range(0, 1) == 0)
                id = ID_W'($urandom_range(0, 7));
        end
        else if (pick < 65)
        begin
            mode = MODE_ACK;
            if (pending.size() > 0 && $urandom_range(0, 3) != 0)
                id = pending[$urandom_range(0, pending.size() - 1)].id;
        end
        else if (pick < 95)
            mode = MODE_TICK;
        else
            mode = MODE_NONE;
        offer_item(mode, id, typ, stamp);
        apply_item(mode, id, typ, stamp);
    endtask

    // one register write; valid stays up so writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        if (index == CFG_WAIT_SECS)
            timeout_secs = data[TIMEOUT_W-1:0];
        else
            retry_limit = data[RETRY_W-1:0];
    endtask

    // stop offering, wait for every owed report, then let the block go quiet
    task automatic drain_reports(input int settle);
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic check_report();
        result_t got;
        result_t want;
        got.ev      = report_bus.event_res;
        got.id      = report_bus.out_id;
        got.typ     = report_bus.out_type;
        got.stamp   = report_bus.out_stamp;
        got.retries = report_bus.retry_count;
        got.last    = report_bus.last;
        if (awaited.size() == 0)
            note_mismatch($sformatf("report with none owed: event %0d id %h", got.ev, got.id));
        else
        begin
            want = awaited.pop_front();
            if (got.ev !== want.ev)
                note_mismatch($sformatf("event_res %0d, owed %0d (id %h)",
                                        got.ev, want.ev, want.id));
            if (got.id !== want.id)
                note_mismatch($sformatf("out_id %h, owed %h", got.id, want.id));
            if (got.typ !== want.typ)
                note_mismatch($sformatf("out_type %h, owed %h (id %h)",
                                        got.typ, want.typ, want.id));
            if (got.stamp !== want.stamp)
                note_mismatch($sformatf("out_stamp %h, owed %h (id %h)",
                                        got.stamp, want.stamp, want.id));
            if (got.retries !== want.retries)
                note_mismatch($sformatf("retry_count %0d, owed %0d (id %h)",
                                        got.retries, want.retries, want.id));
            if (got.last !== want.last)
                note_mismatch($sformatf("last %b, owed %b (id %h)",
                                        got.last, want.last, want.id));
        end
    endtask

    // report side: checks each report and stalls at random, once for a long stretch
    initial
    begin
        int stall_left;
        stall_left = 0;
        report_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (report_bus.valid && report_bus.ready)
            begin
                check_report();
                stall_left = eager_sink ? 0 : draw_wait();
            end
            if (hold_go)
            begin
                hold_go    = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                report_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                report_bus.ready <= 1'b1;
        end
    end

    // request side and phase control
    initial
    begin
        plan_row_t            plan[PLAN_ROWS];
        logic [CFG_DAT_W-1:0] timeout_set[PHASES];
        logic [CFG_DAT_W-1:0] retry_set[PHASES];
        result_t              listed;
        int                   r;
        int                   p;
        int                   k;
        int                   base;

        item_bus.valid      <= 1'b0;
        item_bus.mode       <= MODE_ADD;
        item_bus.msg_id     <= '0;
        item_bus.msg_type   <= '0;
        item_bus.orig_stamp <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= CFG_WAIT_SECS;
        cfg_bus.data        <= '0;
        rst_n               <= 1'b0;

        now_secs     = '0;
        timeout_secs = WAIT_SECS_RST;
        retry_limit  = RETRY_MAX_RST;

        // runs at reset settings: timeout 3 s, 3 retries
        plan = '{
            plan_row(MODE_NONE, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, SILENT),
            plan_row(MODE_ACK,  32'h0000_0000, 4'h0, 32'h0000_0000, SILENT),
            plan_row(MODE_TICK, 32'h0000_0000, 4'h0, 32'h0000_0000, SILENT),
            plan_row(MODE_ADD,  32'h0000_0000, 4'h0, 32'h0000_0000, SILENT),
            plan_row(MODE_ADD,  32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, SILENT),
            plan_row(MODE_ADD,  32'hFFFF_FFFF, 4'h5, 32'h1234_5678, SILENT),
            plan_row(MODE_ADD,  32'h0000_0001, 4'h1, 32'h8000_0000, SILENT),
            plan_row(MODE_ADD,  32'h8000_0000, 4'h2, 32'h0000_0001, SILENT),
            plan_row(MODE_ADD,  32'h5555_5555, 4'h3, 32'hAAAA_AAAA, SILENT),
            plan_row(MODE_ADD,  32'hAAAA_AAAA, 4'hC, 32'h5555_5555, SILENT),
            plan_row(MODE_ADD,  32'h0000_0010, 4'h4, 32'h0000_0100, SILENT),
            plan_row(MODE_ADD,  32'h0000_0011, 4'h6, 32'h0000_0101, SILENT),
            plan_row(MODE_ADD,  32'h0000_0012, 4'h7, 32'h0000_0102, SILENT),
            plan_row(MODE_ADD,  32'h0000_0013, 4'h8, 32'h0000_0103, SILENT),
            plan_row(MODE_ADD,  32'h0000_0014, 4'h9, 32'h0000_0104, SILENT),
            plan_row(MODE_ADD,  32'h0000_0015, 4'hA, 32'h0000_0105, SILENT),
            plan_row(MODE_ADD,  32'h0000_0016, 4'hB, 32'h0000_0106, SILENT),
            plan_row(MODE_ADD,  32'h0000_0017, 4'hD, 32'h0000_0107, SILENT),
            plan_row(MODE_ADD,  32'h0000_0018, 4'hE, 32'h0000_0108, SILENT),
            // table full
            plan_row(MODE_ADD,  32'hA5A5_A5A5, 4'hA, 32'h5A5A_5A5A, DROPPED),
            // duplicate id: only the older entry goes
            plan_row(MODE_ACK,  32'hFFFF_FFFF, 4'h0, 32'h0000_0000, SILENT),
            plan_row(MODE_ADD,  32'hC0DE_0001, 4'h1, 32'hFEED_0001, SILENT),
            plan_row(MODE_TICK, 32'h0000_0000, 4'h0, 32'h0000_0000, SILENT),
            plan_row(MODE_TICK, 32'h0000_0000, 4'h0, 32'h0000_0000, SILENT),
            // all sixteen due at once: a full burst of resends
            plan_row(MODE_TICK, 32'h0000_0000, 4'h0, 32'h0000_0000, PREDICTED)
        };

        // give up at once, zero timeout, extremes, long hold, short, reset values
        timeout_set = '{8'd1, 8'd0, 8'hFF, 8'd1, 8'd2, 8'd3};
        retry_set   = '{8'd0, 8'd15, 8'hF2, 8'd15, 8'd1, 8'd3};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (r = 0; r < PLAN_ROWS; r++)
        begin
            offer_item(plan[r].mode, plan[r].id, plan[r].typ, plan[r].stamp);
            base = awaited.size();
            apply_item(plan[r].mode, plan[r].id, plan[r].typ, plan[r].stamp);
            if (plan[r].outcome != PREDICTED)
            begin
                while (awaited.size() > base)
                    awaited.delete(awaited.size() - 1);
                if (plan[r].outcome == DROPPED)
                begin
                    listed.ev      = EV_DROPPED;
                    listed.id      = plan[r].id;
                    listed.typ     = plan[r].typ;
                    listed.stamp   = plan[r].stamp;
                    listed.retries = '0;
                    listed.last    = 1'b1;
                    awaited.insert(awaited.size(), listed);
                end
            end
        end

        // random phases, registers rewritten only with the block idle
        for (p = 0; p < PHASES; p++)
        begin
            drain_reports(SETTLE_CYCLES);
            write_reg(CFG_WAIT_SECS, timeout_set[p]);
            write_reg(CFG_RETRY_MAX, retry_set[p]);
            cfg_bus.valid <= 1'b0;
            eager_source = (p == 4);
            eager_sink   = (p == 2);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // sender pause until every owed report is in
                if (k == PHASE_ITEMS / 2)
                    drain_reports(0);
                // report side holds off while requests keep coming back to back
                if (p == HOLD_PHASE && k == 8)
                begin
                    hold_go      = 1'b1;
                    eager_source = 1'b1;
                end
                if (p == HOLD_PHASE && k == 28)
                    eager_source = 1'b0;
                offer_random_item();
            end
        end

        drain_reports(SETTLE_CYCLES);
        if (miss_count == 0)
            $display("** ack_retransmit_table: PASSED **");
        else
            $display("** ack_retransmit_table: FAILED **");
        $finish;
    end

    // hang guard
    initial
    begin
        #5_000_000;
        $display("** ack_retransmit_table: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
